// ===== rtl/core/mkd_pkg.sv =====
// ----------------------------------------------------------------------------
// Morse key decoder package
// Shared codes, types and the fixed Morse tree table.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int NODE_BITS    = 6;
  localparam int SYM_BITS     = 7;
  localparam int SEG_BITS     = 8;
  localparam int EVENT_BITS   = 3;
  localparam int MODE_BITS    = 2;
  localparam int CFG_BITS     = 16;
  localparam int REG_IDX_BITS = 2;

  typedef logic [NODE_BITS-1:0]    node_idx_t;
  typedef logic [SYM_BITS-1:0]     sym_t;
  typedef logic [SEG_BITS-1:0]     seg_t;
  typedef logic [EVENT_BITS-1:0]   event_t;
  typedef logic [MODE_BITS-1:0]    mode_t;
  typedef logic [CFG_BITS-1:0]     cfg_word_t;
  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  // Tree node: letter, segment code, children (0 = no child)
  typedef struct packed {
    sym_t      sym;
    seg_t      seg;
    node_idx_t dit;
    node_idx_t dash;
  } morse_node_t;

  // Per-item control from the step logic to the history and the event output
  typedef struct packed {
    event_t ev;
    logic   push;
    logic   blank;
    seg_t   push_seg;
  } step_ctl_t;

  localparam node_idx_t NODE_ROOT   = 6'd0;
  localparam seg_t      SEG_INVALID = 8'hBF;
  localparam seg_t      SEG_BLANK   = 8'hFF;

  // Timeout modes
  localparam mode_t MODE_NONE   = 2'd0;
  localparam mode_t MODE_SYMBOL = 2'd1;
  localparam mode_t MODE_SLEEP  = 2'd2;

  // Event codes
  localparam event_t EV_NONE   = 3'd0;
  localparam event_t EV_DIT    = 3'd1;
  localparam event_t EV_DASH   = 3'd2;
  localparam event_t EV_SYMBOL = 3'd3;
  localparam event_t EV_SLEEP  = 3'd4;

  // Configuration register indexes and reset values
  localparam reg_idx_t REG_DIT_LENGTH  = 2'd0;
  localparam reg_idx_t REG_SYMBOL_GAP  = 2'd1;
  localparam reg_idx_t REG_SLEEP_DELAY = 2'd2;

  localparam cfg_word_t RST_DIT_LENGTH  = 16'd1536;
  localparam cfg_word_t RST_SYMBOL_GAP  = 16'd6144;
  localparam cfg_word_t RST_SLEEP_DELAY = 16'd18432;

  function automatic morse_node_t mk_node(input sym_t s, input seg_t g,
                                          input node_idx_t d, input node_idx_t h);
    morse_node_t n;
    n.sym  = s;
    n.seg  = g;
    n.dit  = d;
    n.dash = h;
    return n;
  endfunction

  // Morse tree ROM; indexes past the last node read as root
  function automatic morse_node_t node_rom(input node_idx_t idx);
    morse_node_t n;
    unique case (idx)
      6'd1:    n = mk_node(7'h45, 8'h06, 6'd3,  6'd4);
      6'd2:    n = mk_node(7'h54, 8'hBF, 6'd5,  6'd6);
      6'd3:    n = mk_node(7'h49, 8'h79, 6'd7,  6'd8);
      6'd4:    n = mk_node(7'h41, 8'h08, 6'd9,  6'd10);
      6'd5:    n = mk_node(7'h4E, 8'hBF, 6'd11, 6'd12);
      6'd6:    n = mk_node(7'h4D, 8'hBF, 6'd13, 6'd14);
      6'd7:    n = mk_node(7'h53, 8'h12, 6'd15, 6'd16);
      6'd8:    n = mk_node(7'h55, 8'h41, 6'd17, 6'd18);
      6'd9:    n = mk_node(7'h52, 8'hBF, 6'd19, 6'd0);
      6'd10:   n = mk_node(7'h57, 8'hBF, 6'd20, 6'd21);
      6'd11:   n = mk_node(7'h44, 8'h40, 6'd22, 6'd23);
      6'd12:   n = mk_node(7'h4B, 8'hBF, 6'd24, 6'd25);
      6'd13:   n = mk_node(7'h47, 8'h02, 6'd26, 6'd27);
      6'd14:   n = mk_node(7'h4F, 8'h40, 6'd28, 6'd29);
      6'd15:   n = mk_node(7'h48, 8'h09, 6'd35, 6'd34);
      6'd16:   n = mk_node(7'h56, 8'hBF, 6'd0,  6'd33);
      6'd17:   n = mk_node(7'h46, 8'h0E, 6'd0,  6'd0);
      6'd18:   n = mk_node(7'h00, 8'hBF, 6'd0,  6'd32);
      6'd19:   n = mk_node(7'h4C, 8'h47, 6'd0,  6'd0);
      6'd20:   n = mk_node(7'h50, 8'h0C, 6'd0,  6'd0);
      6'd21:   n = mk_node(7'h4A, 8'h61, 6'd0,  6'd31);
      6'd22:   n = mk_node(7'h42, 8'h00, 6'd36, 6'd0);
      6'd23:   n = mk_node(7'h58, 8'hBF, 6'd0,  6'd0);
      6'd24:   n = mk_node(7'h43, 8'h46, 6'd0,  6'd0);
      6'd25:   n = mk_node(7'h59, 8'hBF, 6'd0,  6'd0);
      6'd26:   n = mk_node(7'h5A, 8'hBF, 6'd37, 6'd0);
      6'd27:   n = mk_node(7'h51, 8'hBF, 6'd0,  6'd0);
      6'd28:   n = mk_node(7'h00, 8'hBF, 6'd38, 6'd0);
      6'd29:   n = mk_node(7'h00, 8'hBF, 6'd39, 6'd30);
      6'd30:   n = mk_node(7'h30, 8'hC0, 6'd0,  6'd0);
      6'd31:   n = mk_node(7'h31, 8'hF9, 6'd0,  6'd0);
      6'd32:   n = mk_node(7'h32, 8'hA4, 6'd0,  6'd0);
      6'd33:   n = mk_node(7'h33, 8'hB0, 6'd0,  6'd0);
      6'd34:   n = mk_node(7'h34, 8'h99, 6'd0,  6'd0);
      6'd35:   n = mk_node(7'h35, 8'h92, 6'd0,  6'd0);
      6'd36:   n = mk_node(7'h36, 8'h82, 6'd0,  6'd0);
      6'd37:   n = mk_node(7'h37, 8'hF8, 6'd0,  6'd0);
      6'd38:   n = mk_node(7'h38, 8'h80, 6'd0,  6'd0);
      6'd39:   n = mk_node(7'h39, 8'h98, 6'd0,  6'd0);
      default: n = mk_node(7'h00, 8'hFF, 6'd1,  6'd2);
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/morse_key_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Morse key decoder unit
// Decodes sampled key levels into Morse symbols and a seven-segment history.
// ----------------------------------------------------------------------------
// Takes one key sample per item and returns one result item per sample, at a
// sustained rate of one item per clock while the output is not stalled. An item
// sits in the input stage, where the decoder state is read from a single-entry
// memory, updated and written back; the last write is forwarded so consecutive
// items see it. The result is then registered in the output register; a stall
// on the output holds the item in the input stage. The digit history is blanked
// (0xFF) at reset and the tree starts at the root. Configuration writes must be
// issued only while no item is in flight.
module morse_key_decoder_unit #(
  parameter int TIMER_BITS     = 16,
  parameter int HISTORY_DIGITS = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  mkd_pkg::reg_idx_t        cfg_index,
  input  mkd_pkg::cfg_word_t       cfg_data,
  // Key samples
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     key_down,
  // Results
  output logic                     out_valid,
  input  logic                     out_ready,
  output mkd_pkg::event_t          event_res,
  output mkd_pkg::sym_t            current_symbol,
  output mkd_pkg::seg_t            current_segments,
  output mkd_pkg::seg_t            digit_oldest,
  output mkd_pkg::seg_t            digit_middle,
  output mkd_pkg::seg_t            digit_newest
);
  import mkd_pkg::*;

  localparam int STW = NODE_BITS + 1 + MODE_BITS + TIMER_BITS;
  localparam logic [STW-1:0] STATE_RESET = {NODE_ROOT, 1'b0, MODE_NONE,
                                            {TIMER_BITS{1'b0}}};

  cfg_word_t             dit_length;
  cfg_word_t             symbol_gap;
  cfg_word_t             sleep_delay;

  logic                  s1_valid;
  logic                  s1_key;
  logic                  out_free;
  logic                  fire;

  logic                  mem_wr_en;
  logic [STW-1:0]        mem_wr_data;
  logic [STW-1:0]        mem_rd_data;

  node_idx_t             st_node;
  logic                  st_pressed;
  mode_t                 st_mode;
  logic [TIMER_BITS-1:0] st_tick;
  node_idx_t             node_next;
  logic                  pressed_next;
  mode_t                 mode_next;
  logic [TIMER_BITS-1:0] tick_next;
  step_ctl_t             ctl;
  sym_t                  sym_next;
  seg_t                  seg_next;

  seg_t                  hist [HISTORY_DIGITS];

  // Configuration registers
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      dit_length  <= RST_DIT_LENGTH;
      symbol_gap  <= RST_SYMBOL_GAP;
      sleep_delay <= RST_SLEEP_DELAY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIT_LENGTH:  dit_length  <= cfg_data;
        REG_SYMBOL_GAP:  symbol_gap  <= cfg_data;
        REG_SLEEP_DELAY: sleep_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: input stage feeds the output register
  assign out_free = !out_valid || out_ready;
  assign fire     = s1_valid && out_free;
  assign in_ready = !rst && (!s1_valid || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_key <= key_down;
    end
  end

  // Decoder state memory; reset writes the initial record
  assign mem_wr_en   = rst || fire;
  assign mem_wr_data = rst ? STATE_RESET
                           : {node_next, pressed_next, mode_next, tick_next};

  mkd_state_mem #(
    .WIDTH (STW)
  ) u_state_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  assign {st_node, st_pressed, st_mode, st_tick} = mem_rd_data;

  mkd_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .key_down     (s1_key),
    .dit_length   (dit_length),
    .symbol_gap   (symbol_gap),
    .sleep_delay  (sleep_delay),
    .node         (st_node),
    .pressed      (st_pressed),
    .mode         (st_mode),
    .tick         (st_tick),
    .node_next    (node_next),
    .pressed_next (pressed_next),
    .mode_next    (mode_next),
    .tick_next    (tick_next),
    .ctl          (ctl),
    .sym_out      (sym_next),
    .seg_out      (seg_next)
  );

  // Digit history, index 0 oldest
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DIGITS; i++) begin
        hist[i] <= SEG_BLANK;
      end
    end else if (fire) begin
      if (ctl.blank) begin
        for (int i = 0; i < HISTORY_DIGITS; i++) begin
          hist[i] <= SEG_BLANK;
        end
      end else if (ctl.push) begin
        for (int i = 0; i < HISTORY_DIGITS - 1; i++) begin
          hist[i] <= hist[i + 1];
        end
        hist[HISTORY_DIGITS - 1] <= ctl.push_seg;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      event_res        <= ctl.ev;
      current_symbol   <= sym_next;
      current_segments <= seg_next;
    end
  end

  // History taps, newest first; missing places read blank
  assign digit_newest = hist[HISTORY_DIGITS - 1];

  generate
    if (HISTORY_DIGITS >= 2) begin : g_middle
      assign digit_middle = hist[HISTORY_DIGITS - 2];
    end else begin : g_middle_blank
      assign digit_middle = SEG_BLANK;
    end
    if (HISTORY_DIGITS >= 3) begin : g_oldest
      assign digit_oldest = hist[HISTORY_DIGITS - 3];
    end else begin : g_oldest_blank
      assign digit_oldest = SEG_BLANK;
    end
  endgenerate

endmodule

// ===== rtl/core/mkd_state_mem.sv =====
// ----------------------------------------------------------------------------
// Morse key decoder state memory
// Single-entry synchronous memory with a registered read and write forwarding.
// ----------------------------------------------------------------------------
module mkd_state_mem #(
  parameter int WIDTH = 25
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [0:0];
  logic [WIDTH-1:0] rd_q;
  logic             fwd_valid;
  logic [WIDTH-1:0] fwd_data;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[0] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rd_q <= mem[0];
  end

  // Last write bypasses the stale read
  always_ff @(posedge clk) begin
    fwd_valid <= wr_en;
    fwd_data  <= wr_data;
  end

  assign rd_data = fwd_valid ? fwd_data : rd_q;

endmodule

// ===== rtl/core/mkd_step.sv =====
// ----------------------------------------------------------------------------
// Morse key decoder step logic
// Classifies presses, walks the tree and runs the symbol and sleep timeouts.
// ----------------------------------------------------------------------------
module mkd_step #(
  parameter int TIMER_BITS = 16
) (
  input  logic                   key_down,
  input  mkd_pkg::cfg_word_t     dit_length,
  input  mkd_pkg::cfg_word_t     symbol_gap,
  input  mkd_pkg::cfg_word_t     sleep_delay,
  input  mkd_pkg::node_idx_t     node,
  input  logic                   pressed,
  input  mkd_pkg::mode_t         mode,
  input  logic [TIMER_BITS-1:0]  tick,
  output mkd_pkg::node_idx_t     node_next,
  output logic                   pressed_next,
  output mkd_pkg::mode_t         mode_next,
  output logic [TIMER_BITS-1:0]  tick_next,
  output mkd_pkg::step_ctl_t     ctl,
  output mkd_pkg::sym_t          sym_out,
  output mkd_pkg::seg_t          seg_out
);
  import mkd_pkg::*;

  localparam int CW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

  logic [TIMER_BITS-1:0] tick_inc;
  logic [CW-1:0]         tick_w;
  logic [CW-1:0]         tick_inc_w;
  logic [CW-1:0]         dit_w;
  logic [CW-1:0]         symto_w;
  logic [CW-1:0]         sleep_w;
  morse_node_t           cur;
  morse_node_t           nxt;

  // Saturating tick counter
  assign tick_inc   = (&tick) ? tick : tick + 1'b1;
  assign tick_w     = CW'(tick);
  assign tick_inc_w = CW'(tick_inc);
  assign dit_w      = CW'(dit_length);
  assign symto_w    = CW'(symbol_gap);
  assign sleep_w    = CW'(sleep_delay);

  assign cur = node_rom(node);

  // Press, release, or timeout handling
  always_comb begin
    node_next    = node;
    pressed_next = pressed;
    mode_next    = mode;
    tick_next    = tick_inc;
    ctl.ev       = EV_NONE;
    ctl.push     = 1'b0;
    ctl.blank    = 1'b0;
    ctl.push_seg = cur.seg;
    if (!pressed && key_down) begin
      pressed_next = 1'b1;
      tick_next    = '0;
      mode_next    = MODE_NONE;
    end else if (pressed && !key_down) begin
      pressed_next = 1'b0;
      if (tick_w < dit_w) begin
        ctl.ev = EV_DIT;
        if (cur.dit != NODE_ROOT) begin
          node_next = cur.dit;
        end
      end else begin
        ctl.ev = EV_DASH;
        if (cur.dash != NODE_ROOT) begin
          node_next = cur.dash;
        end
      end
      tick_next = '0;
      mode_next = MODE_SYMBOL;
    end else if (mode == MODE_SYMBOL && tick_inc_w >= symto_w) begin
      ctl.ev    = EV_SYMBOL;
      ctl.push  = (cur.seg != SEG_INVALID);
      node_next = NODE_ROOT;
      tick_next = '0;
      mode_next = MODE_SLEEP;
    end else if (mode == MODE_SLEEP && tick_inc_w >= sleep_w) begin
      ctl.ev    = EV_SLEEP;
      ctl.blank = 1'b1;
      node_next = NODE_ROOT;
      tick_next = '0;
      mode_next = MODE_NONE;
    end
  end

  // Node shown after this item
  assign nxt     = node_rom(node_next);
  assign sym_out = nxt.sym;
  assign seg_out = nxt.seg;

endmodule

// ===== tb/sv/morse_key_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse key decoder unit testbench
// Drives key samples through the decoder and checks every result item
// against a cycle-free model of the tree walk, the timeouts and the digit
// history. Runs directed keying, lowered timeouts, back-pressure, large
// register values and random keying under several register settings.
// ----------------------------------------------------------------------------
module morse_key_decoder_unit_tb;

  import mkd_pkg::*;

  localparam reg_idx_t REG_UNUSED = 2'd3;

  typedef struct {
    event_t ev;
    sym_t   sym;
    seg_t   seg;
    seg_t   oldest;
    seg_t   middle;
    seg_t   newest;
  } key_result_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  reg_idx_t  cfg_index = REG_DIT_LENGTH;
  cfg_word_t cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  logic      key_down = 1'b0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  event_t    event_res;
  sym_t      current_symbol;
  seg_t      current_segments;
  seg_t      digit_oldest;
  seg_t      digit_middle;
  seg_t      digit_newest;

  // Decoder shadow state and register copies
  node_idx_t tree_pos = NODE_ROOT;
  logic      key_is_down = 1'b0;
  logic [15:0] tick_cnt = '0;
  mode_t     armed = MODE_NONE;
  seg_t      hist_old = SEG_BLANK;
  seg_t      hist_mid = SEG_BLANK;
  seg_t      hist_new = SEG_BLANK;
  cfg_word_t dit_len_cfg = RST_DIT_LENGTH;
  cfg_word_t symbol_to_cfg = RST_SYMBOL_GAP;
  cfg_word_t sleep_to_cfg = RST_SLEEP_DELAY;

  key_result_t decode_q[$];
  int keys_sent = 0;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_request = 0;

  morse_key_decoder_unit dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .key_down         (key_down),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .event_res        (event_res),
    .current_symbol   (current_symbol),
    .current_segments (current_segments),
    .digit_oldest     (digit_oldest),
    .digit_middle     (digit_middle),
    .digit_newest     (digit_newest)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Morse tree: {symbol, segments, dit child, dash child}; 0 child = none
  function automatic morse_node_t morse_tree(input node_idx_t idx);
    morse_node_t n;
    case (idx)
      6'd1:    n = {7'h45, 8'h06, 6'd3, 6'd4};
      6'd2:    n = {7'h54, 8'hBF, 6'd5, 6'd6};
      6'd3:    n = {7'h49, 8'h79, 6'd7, 6'd8};
      6'd4:    n = {7'h41, 8'h08, 6'd9, 6'd10};
      6'd5:    n = {7'h4E, 8'hBF, 6'd11, 6'd12};
      6'd6:    n = {7'h4D, 8'hBF, 6'd13, 6'd14};
      6'd7:    n = {7'h53, 8'h12, 6'd15, 6'd16};
      6'd8:    n = {7'h55, 8'h41, 6'd17, 6'd18};
      6'd9:    n = {7'h52, 8'hBF, 6'd19, 6'd0};
      6'd10:   n = {7'h57, 8'hBF, 6'd20, 6'd21};
      6'd11:   n = {7'h44, 8'h40, 6'd22, 6'd23};
      6'd12:   n = {7'h4B, 8'hBF, 6'd24, 6'd25};
      6'd13:   n = {7'h47, 8'h02, 6'd26, 6'd27};
      6'd14:   n = {7'h4F, 8'h40, 6'd28, 6'd29};
      6'd15:   n = {7'h48, 8'h09, 6'd35, 6'd34};
      6'd16:   n = {7'h56, 8'hBF, 6'd0, 6'd33};
      6'd17:   n = {7'h46, 8'h0E, 12'd0};
      6'd18:   n = {7'h00, 8'hBF, 6'd0, 6'd32};
      6'd19:   n = {7'h4C, 8'h47, 12'd0};
      6'd20:   n = {7'h50, 8'h0C, 12'd0};
      6'd21:   n = {7'h4A, 8'h61, 6'd0, 6'd31};
      6'd22:   n = {7'h42, 8'h00, 6'd36, 6'd0};
      6'd23:   n = {7'h58, 8'hBF, 12'd0};
      6'd24:   n = {7'h43, 8'h46, 12'd0};
      6'd25:   n = {7'h59, 8'hBF, 12'd0};
      6'd26:   n = {7'h5A, 8'hBF, 6'd37, 6'd0};
      6'd27:   n = {7'h51, 8'hBF, 12'd0};
      6'd28:   n = {7'h00, 8'hBF, 6'd38, 6'd0};
      6'd29:   n = {7'h00, 8'hBF, 6'd39, 6'd30};
      6'd30:   n = {7'h30, 8'hC0, 12'd0};
      6'd31:   n = {7'h31, 8'hF9, 12'd0};
      6'd32:   n = {7'h32, 8'hA4, 12'd0};
      6'd33:   n = {7'h33, 8'hB0, 12'd0};
      6'd34:   n = {7'h34, 8'h99, 12'd0};
      6'd35:   n = {7'h35, 8'h92, 12'd0};
      6'd36:   n = {7'h36, 8'h82, 12'd0};
      6'd37:   n = {7'h37, 8'hF8, 12'd0};
      6'd38:   n = {7'h38, 8'h80, 12'd0};
      6'd39:   n = {7'h39, 8'h98, 12'd0};
      default: n = {7'h00, 8'hFF, 6'd1, 6'd2};
    endcase
    return n;
  endfunction

  // Advance the shadow decoder by one key sample and queue the result
  task automatic decode_tick(input logic level);
    key_result_t r;
    morse_node_t n;
    r.ev = EV_NONE;
    if (!key_is_down && level) begin
      key_is_down = 1'b1;
      tick_cnt = '0;
      armed = MODE_NONE;
    end else if (key_is_down && !level) begin
      // release: classify the press and step the tree
      key_is_down = 1'b0;
      n = morse_tree(tree_pos);
      if (tick_cnt < dit_len_cfg) begin
        r.ev = EV_DIT;
        if (n.dit != NODE_ROOT) tree_pos = n.dit;
      end else begin
        r.ev = EV_DASH;
        if (n.dash != NODE_ROOT) tree_pos = n.dash;
      end
      tick_cnt = '0;
      armed = MODE_SYMBOL;
    end else begin
      if (tick_cnt != 16'hFFFF) tick_cnt++;
      if (armed == MODE_SYMBOL && tick_cnt >= symbol_to_cfg) begin
        n = morse_tree(tree_pos);
        if (n.seg != SEG_INVALID) begin
          hist_old = hist_mid;
          hist_mid = hist_new;
          hist_new = n.seg;
        end
        tree_pos = NODE_ROOT;
        tick_cnt = '0;
        armed = MODE_SLEEP;
        r.ev = EV_SYMBOL;
      end else if (armed == MODE_SLEEP && tick_cnt >= sleep_to_cfg) begin
        hist_old = SEG_BLANK;
        hist_mid = SEG_BLANK;
        hist_new = SEG_BLANK;
        tree_pos = NODE_ROOT;
        tick_cnt = '0;
        armed = MODE_NONE;
        r.ev = EV_SLEEP;
      end
    end
    n = morse_tree(tree_pos);
    r.sym = n.sym;
    r.seg = n.seg;
    r.oldest = hist_old;
    r.middle = hist_mid;
    r.newest = hist_new;
    decode_q.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, field, got,
               want);
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    key_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (decode_q.size() == 0) begin
        report_mismatch("unexpected result item", int'(event_res), 0);
      end else begin
        want = decode_q.pop_front();
        if (event_res !== want.ev)
          report_mismatch("event_res", int'(event_res), int'(want.ev));
        if (current_symbol !== want.sym)
          report_mismatch("current_symbol", int'(current_symbol), int'(want.sym));
        if (current_segments !== want.seg)
          report_mismatch("current_segments", int'(current_segments), int'(want.seg));
        if (digit_oldest !== want.oldest)
          report_mismatch("digit_oldest", int'(digit_oldest), int'(want.oldest));
        if (digit_middle !== want.middle)
          report_mismatch("digit_middle", int'(digit_middle), int'(want.middle));
        if (digit_newest !== want.newest)
          report_mismatch("digit_newest", int'(digit_newest), int'(want.newest));
      end
    end
  end

  // Result sink: random stalls, plus long holds on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (int'($urandom_range(99)) >= sink_idle_pct);
      end
    end
  end

  // Send one key sample item; valid stays up for a back-to-back item
  task automatic send_key(input logic level);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key_down <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_tick(level);
    keys_sent++;
  endtask

  task automatic idle_key(input int n);
    repeat (n) send_key(1'b0);
  endtask

  // Press, hold for the given ticks, release
  task automatic key_press(input int hold);
    send_key(1'b1);
    repeat (hold) send_key(1'b1);
    send_key(1'b0);
  endtask

  // Stop sending and wait until every queued result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (decode_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Caller lowers cfg_valid after the last write
  task automatic write_reg(input reg_idx_t idx, input cfg_word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DIT_LENGTH:  dit_len_cfg = val;
      REG_SYMBOL_GAP:  symbol_to_cfg = val;
      REG_SLEEP_DELAY: sleep_to_cfg = val;
      default: ;
    endcase
  endtask

  task automatic configure(input cfg_word_t dit_len, input cfg_word_t sym_to,
                           input cfg_word_t slp_to);
    wait_idle();
    write_reg(REG_DIT_LENGTH, dit_len);
    write_reg(REG_SYMBOL_GAP, sym_to);
    write_reg(REG_SLEEP_DELAY, slp_to);
    cfg_valid <= 1'b0;
  endtask

  // One well-formed letter of random marks, then a random letter gap
  task automatic send_letter();
    int marks;
    marks = $urandom_range(6, 1);
    for (int m = 0; m < marks; m++) begin
      if ($urandom_range(1))
        key_press(dit_len_cfg + $urandom_range(3));
      else
        key_press($urandom_range(dit_len_cfg - 1));
      // gap short enough to keep the symbol open
      if (m + 1 < marks) idle_key($urandom_range(symbol_to_cfg - 1));
    end
    case ($urandom_range(9))
      0, 1:    idle_key(symbol_to_cfg + sleep_to_cfg + $urandom_range(3));
      2:       ;
      default: idle_key(symbol_to_cfg + $urandom_range(sleep_to_cfg - 1));
    endcase
  endtask

  // Reset outputs, dit, dash, commits, cancel by press, blanking
  task automatic test_directed();
    idle_key(2);
    configure(16'd2, 16'd2, 16'd3);
    key_press(0);
    idle_key(2);
    key_press(3);
    idle_key(2);
    idle_key(1);
    key_press(0);
    idle_key(5);
    idle_key(2);
  endtask

  // Timeouts lowered under an armed count fire on the next tick
  task automatic test_lowered_timeouts();
    configure(16'd1, 16'd12, 16'd30);
    key_press(0);
    idle_key(2);
    wait_idle();
    write_reg(REG_SYMBOL_GAP, 16'd1);
    write_reg(REG_UNUSED, 16'd1);
    cfg_valid <= 1'b0;
    idle_key(3);
    wait_idle();
    write_reg(REG_SLEEP_DELAY, 16'd1);
    cfg_valid <= 1'b0;
    idle_key(2);
  endtask

  // Long sink hold while items keep coming, then a full drain
  task automatic test_backpressure();
    hold_request = 300;
    repeat (60) send_key(1'($urandom_range(1)));
    wait_idle();
  endtask

  // Largest register values: long holds stay dits and no timeout fires
  task automatic test_large_registers();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
    key_press(24);
    idle_key(20);
    key_press(6);
    idle_key(10);
  endtask

  // Mostly letters with random content, some random key noise
  task automatic test_random_keying(input int n_keys);
    int stop_at;
    stop_at = keys_sent + n_keys;
    while (keys_sent < stop_at) begin
      if ($urandom_range(99) < 20)
        send_key(1'($urandom_range(1)));
      else
        send_letter();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 27;
    sink_idle_pct = 80;
    test_directed();
    configure(16'd3, 16'd6, 16'd10);
    test_random_keying(470);

    send_idle_pct = 80;
    sink_idle_pct = 27;
    test_backpressure();
    test_lowered_timeouts();
    configure(cfg_word_t'($urandom_range(6, 1)), cfg_word_t'($urandom_range(12, 1)),
              cfg_word_t'($urandom_range(20, 1)));
    test_random_keying(470);

    send_idle_pct = 0;
    sink_idle_pct = 0;
    test_large_registers();
    configure(16'd1, 16'd1, 16'd1);
    test_random_keying(470);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
